/* rtl/core/cpu8080_memory_io_responder_core_macros.svh */
// assertion macros used by the responder core rtl
`ifndef CPU8080_MEMORY_IO_RESPONDER_CORE_MACROS_SVH
`define CPU8080_MEMORY_IO_RESPONDER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define C80MIO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define C80MIO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/c80mio_pkg.sv */
// types and constants of the 8080 memory and i/o responder
package c80mio_pkg;

  localparam logic [15:0] RAM_BASE  = 16'h8000;
  localparam logic [7:0]  PORT_DATA = 8'h00;
  localparam logic [7:0]  PORT_STAT = 8'h01;
  localparam logic [7:0]  BYTE_FF   = 8'hFF;

  localparam int unsigned ST_MEMR = 7;
  localparam int unsigned ST_INP  = 6;
  localparam int unsigned ST_OUT  = 4;
  localparam int unsigned ST_WO_N = 1;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    KIND_ROM_RD  = 3'd0,
    KIND_RAM_RD  = 3'd1,
    KIND_TX      = 3'd2,
    KIND_RAM_WR  = 3'd3,
    KIND_STAT_RD = 3'd4,
    KIND_RX_RD   = 3'd5,
    KIND_NONE    = 3'd6,
    KIND_LOAD    = 3'd7
  } kind_t;

  // where the read byte comes from once memory data is back
  typedef enum logic [1:0] {
    SRC_ZERO = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2,
    SRC_IO   = 2'd3
  } rd_src_t;

  typedef struct packed {
    kind_t      kind;
    rd_src_t    src;
    logic [7:0] io_byte;
    logic       drive;
    logic       tx_strobe;
    logic       rx_pop;
    logic       ram_re;
    logic       ram_we;
    logic       rom_re;
    logic       rom_we;
    logic       irq_nxt;
  } c80mio_dec_t;

endpackage

/* rtl/core/c80mio_decode.sv */
// bus cycle decode: priority rules, memory enables and interrupt update
module c80mio_decode #(
  parameter int unsigned RAM_BYTES = 12288,
  parameter int unsigned ROM_BYTES = 32768
) (
  input  logic                    action,
  input  logic [7:0]              status,
  input  logic [15:0]             address,
  input  logic                    rx_ready,
  input  logic                    tx_ready,
  input  logic [7:0]              rx_byte,
  input  logic                    rx_more,
  input  logic                    irq,
  output c80mio_pkg::c80mio_dec_t dec
);
  import c80mio_pkg::*;

  localparam logic [15:0] RAM_TOP = 16'(RAM_BASE + RAM_BYTES);
  localparam logic [16:0] ROM_TOP = 17'(ROM_BYTES);

  logic       memr, inp, outc, wo_n;
  logic [7:0] port;
  logic       in_ram, in_rom;

  assign memr   = status[ST_MEMR];
  assign inp    = status[ST_INP];
  assign outc   = status[ST_OUT];
  assign wo_n   = status[ST_WO_N];
  assign port   = address[7:0];
  assign in_ram = (address >= RAM_BASE) && (address < RAM_TOP);
  assign in_rom = {1'b0, address} < ROM_TOP;

  always_comb begin
    dec           = '0;
    dec.kind      = KIND_NONE;
    dec.src       = SRC_ZERO;
    dec.io_byte   = '0;
    dec.irq_nxt   = irq;
    if (action) begin
      dec.kind   = KIND_LOAD;
      dec.rom_we = in_rom;
    end else begin
      priority if (memr && (address < RAM_BASE)) begin
        dec.kind  = KIND_ROM_RD;
        dec.drive = 1'b1;
        if (in_rom) begin
          dec.src    = SRC_ROM;
          dec.rom_re = 1'b1;
        end else begin
          // unfilled rom space reads as all ones
          dec.src     = SRC_IO;
          dec.io_byte = BYTE_FF;
        end
      end else if (memr && in_ram) begin
        dec.kind   = KIND_RAM_RD;
        dec.drive  = 1'b1;
        dec.src    = SRC_RAM;
        dec.ram_re = 1'b1;
      end else if (outc && (port == PORT_DATA)) begin
        dec.kind      = KIND_TX;
        dec.tx_strobe = 1'b1;
      end else if (!wo_n && in_ram) begin
        dec.kind   = KIND_RAM_WR;
        dec.ram_we = 1'b1;
      end else if (inp && (port == PORT_STAT)) begin
        dec.kind    = KIND_STAT_RD;
        dec.drive   = 1'b1;
        dec.src     = SRC_IO;
        dec.io_byte = {6'b0, rx_ready, tx_ready};
      end else if (inp && (port == PORT_DATA)) begin
        dec.kind    = KIND_RX_RD;
        dec.drive   = 1'b1;
        dec.src     = SRC_IO;
        dec.io_byte = rx_byte;
        dec.rx_pop  = 1'b1;
        dec.irq_nxt = 1'b0;
      end else begin
        dec.kind = KIND_NONE;
      end
      if (rx_more) begin
        dec.irq_nxt = 1'b1;
      end
    end
  end

endmodule

/* rtl/core/cpu8080_memory_io_responder_core.sv */
// top level of the 8080 memory and i/o responder
//
// channel  dir  tuser                  tdata (lowest bit up)
// in_      in   [0] action             status, address, write_data, rx_ready,
//                                      tx_ready, rx_byte, rx_more, zero pad
// out_     out  [2:0] cycle_kind       read_data, drive_bus, tx_strobe, tx_byte,
//                                      rx_pop, interrupt_request, zero pad
//
// one beat per clock sustained while out_tready is high and no clearing pass runs;
// a result passes the ram/rom read register, then the output register
// the single ram and rom ports, one access per beat, set the rate
// after reset a clearing pass zeroes the ram, with in_tready low until it is done
// a stalled output holds the output register and the read stage; input then stalls
`include "cpu8080_memory_io_responder_core_macros.svh"

module cpu8080_memory_io_responder_core #(
  parameter int unsigned RAM_BYTES = 12288,
  parameter int unsigned ROM_BYTES = 32768
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // status[7:0], address[23:8], write_data[31:24], rx_ready[32], tx_ready[33],
  // rx_byte[41:34], rx_more[42], zero[47:43]
  input  logic [c80mio_pkg::IN_TDATA_W-1:0]    in_tdata,
  // action[0]
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // read_data[7:0], drive_bus[8], tx_strobe[9], tx_byte[17:10], rx_pop[18],
  // interrupt_request[19], zero[23:20]
  output logic [c80mio_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // cycle_kind[2:0]
  output logic [2:0]                           out_tuser
);
  import c80mio_pkg::*;

  localparam int unsigned RAM_AW = $clog2(RAM_BYTES);
  localparam int unsigned ROM_AW = $clog2(ROM_BYTES);
  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_BYTES - 1);

  // unpack the input beat
  logic [7:0]  f_status;
  logic [15:0] f_address;
  logic [7:0]  f_wdata;
  logic        f_rx_ready, f_tx_ready, f_rx_more;
  logic [7:0]  f_rx_byte;

  assign f_status   = in_tdata[7:0];
  assign f_address  = in_tdata[23:8];
  assign f_wdata    = in_tdata[31:24];
  assign f_rx_ready = in_tdata[32];
  assign f_tx_ready = in_tdata[33];
  assign f_rx_byte  = in_tdata[41:34];
  assign f_rx_more  = in_tdata[42];

  // control state
  logic              clr_busy_r;
  logic [RAM_AW-1:0] clr_idx_r;
  logic              irq_r;
  logic              s1_valid_r;
  logic              out_valid_r;

  // read stage payload
  kind_t      s1_kind_r;
  rd_src_t    s1_src_r;
  logic [7:0] s1_io_r;
  logic       s1_drive_r, s1_txs_r, s1_pop_r, s1_irq_r;
  logic [7:0] s1_txb_r;

  // output register payload
  kind_t      o_kind_r;
  logic [7:0] o_rd_r, o_txb_r;
  logic       o_drive_r, o_txs_r, o_pop_r, o_irq_r;

  c80mio_dec_t dec;
  logic        accept, s1_adv;

  c80mio_decode #(
    .RAM_BYTES (RAM_BYTES),
    .ROM_BYTES (ROM_BYTES)
  ) u_decode (
    .action   (in_tuser),
    .status   (f_status),
    .address  (f_address),
    .rx_ready (f_rx_ready),
    .tx_ready (f_tx_ready),
    .rx_byte  (f_rx_byte),
    .rx_more  (f_rx_more),
    .irq      (irq_r),
    .dec      (dec)
  );

  // handshake: read stage moves on when the output register frees up
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  // work ram: clearing pass owns the write port until done
  logic [7:0]        ram_mem [RAM_BYTES];
  logic [7:0]        ram_q_r;
  logic              ram_we;
  logic [RAM_AW-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [RAM_AW-1:0] ram_addr;

  assign ram_addr  = f_address[RAM_AW-1:0];
  assign ram_we    = clr_busy_r || (accept && dec.ram_we);
  assign ram_waddr = clr_busy_r ? clr_idx_r : ram_addr;
  assign ram_wdata = clr_busy_r ? 8'h00 : f_wdata;

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[ram_waddr] <= ram_wdata;
    end
    if (accept && dec.ram_re) begin
      ram_q_r <= ram_mem[ram_addr];
    end
  end

  // program rom, filled by load beats, untouched by reset
  logic [7:0]        rom_mem [ROM_BYTES];
  logic [7:0]        rom_q_r;
  logic [ROM_AW-1:0] rom_addr;

  assign rom_addr = f_address[ROM_AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && dec.rom_we) begin
      rom_mem[rom_addr] <= f_wdata;
    end
    if (accept && dec.rom_re) begin
      rom_q_r <= rom_mem[rom_addr];
    end
  end

  // clearing pass and interrupt flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      irq_r      <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == CLR_LAST) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (accept) begin
        irq_r <= dec.irq_nxt;
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= dec.kind;
      s1_src_r   <= dec.src;
      s1_io_r    <= dec.io_byte;
      s1_drive_r <= dec.drive;
      s1_txs_r   <= dec.tx_strobe;
      s1_txb_r   <= dec.tx_strobe ? f_wdata : 8'h00;
      s1_pop_r   <= dec.rx_pop;
      s1_irq_r   <= dec.irq_nxt;
    end
  end

  // read byte select once memory data is in
  logic [7:0] s1_rd;

  always_comb begin
    unique case (s1_src_r)
      SRC_ROM:  s1_rd = rom_q_r;
      SRC_RAM:  s1_rd = ram_q_r;
      SRC_IO:   s1_rd = s1_io_r;
      default:  s1_rd = 8'h00;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_kind_r  <= s1_kind_r;
      o_rd_r    <= s1_rd;
      o_drive_r <= s1_drive_r;
      o_txs_r   <= s1_txs_r;
      o_txb_r   <= s1_txb_r;
      o_pop_r   <= s1_pop_r;
      o_irq_r   <= s1_irq_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tdata  = {4'b0, o_irq_r, o_pop_r, o_txb_r, o_txs_r, o_drive_r, o_rd_r};

  // checks
  `C80MIO_ASSERT_NOW(a_no_beat_while_clearing, clr_busy_r, !accept,
    "input beat taken during ram clearing pass")
  `C80MIO_ASSERT_NOW(a_drive_kind, out_valid_r && o_drive_r,
    o_kind_r == KIND_ROM_RD || o_kind_r == KIND_RAM_RD ||
    o_kind_r == KIND_STAT_RD || o_kind_r == KIND_RX_RD,
    "bus driven for a non-read cycle")
  `C80MIO_ASSERT_NOW(a_tx_kind, out_valid_r && o_txs_r, o_kind_r == KIND_TX,
    "tx strobe on a non-send cycle")
  `C80MIO_ASSERT_NEXT(a_s1_hold, s1_valid_r && !s1_adv, s1_valid_r,
    "read stage dropped a beat while stalled")
  `C80MIO_ASSERT_NEXT(a_out_hold, out_valid_r && !out_tready,
    out_valid_r && $stable(o_rd_r) && $stable(o_kind_r),
    "output register changed while stalled")

endmodule
